// ----- rtl/dq_pkg.sv -----
package dq_pkg;

  localparam int DATA_W = 8;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } dq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef struct packed {
    dq_cmd_t           cmd;
    logic [DATA_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    dq_status_t        status;
    logic [OCC_W-1:0]  occupancy;
  } dq_out_t;

  typedef struct packed {
    logic accept;
    logic load;
  } dq_ctl_t;

endpackage

// ----- rtl/double_ended_queue_top.sv -----
// Bounded double-ended queue on a ring of DEPTH slots.
// Input channel (in_valid / in_stall / in_data): one command beat holding
// cmd (push front, push rear, pop front, pop rear) and push_value.
// Output channel (out_valid / out_stall / out_data): exactly one beat per
// command with pop_value (zero unless a pop succeeded), status (ok, pop
// from empty, push into full) and occupancy after the command.
// out_valid rises after the controller accepts a command in S_IDLE and
// loads its result in S_LOAD; the slot memory read is registered and the
// controller takes no new command until it has loaded the last result.
// A refused command changes nothing in the queue.
// While out_stall holds a result, the next command is still taken; its
// result waits inside until the output register is free, and in_stall
// stays high meanwhile.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result. Slot contents are not cleared; empty slots are never read.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  dq_ctl_t ctl;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- rtl/dq_ctrl.sv -----
module dq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output dq_pkg::dq_ctl_t ctl
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign can_load  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    ctl.accept = 1'b0;
    ctl.load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (can_load) begin
          ctl.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/dq_datapath.sv -----
module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dq_pkg::dq_ctl_t ctl,
  input  dq_pkg::dq_in_t  in_data,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  logic [PW-1:0] front_r, front_nxt, rear_r, rear_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] front_next, front_prev, rear_next, rear_prev;
  logic [PW-1:0] addr;
  logic          full, empty, we, re;
  dq_status_t    status_r, status_nxt;
  logic          pop_ok_r, pop_ok_nxt;
  dq_out_t       out_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_next = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_prev = (front_r == '0) ? PW'(DEPTH - 1) : front_r - 1'b1;
  assign rear_next  = (rear_r == PW'(DEPTH - 1)) ? '0 : rear_r + 1'b1;
  assign rear_prev  = (rear_r == '0) ? PW'(DEPTH - 1) : rear_r - 1'b1;

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    addr       = front_r;
    case (in_data.cmd)
      CMD_PUSH_FRONT: begin
        addr = front_prev;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          front_nxt = front_prev;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        addr = rear_r;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          rear_nxt  = rear_next;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        addr = front_r;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          front_nxt  = front_next;
          count_nxt  = count_r - 1'b1;
        end
      end
      CMD_POP_REAR: begin
        addr = rear_prev;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          rear_nxt   = rear_prev;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && we) begin
      mem[addr] <= in_data.push_value;
    end
    if (ctl.accept && re) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
    end else if (ctl.accept) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (ctl.load) begin
      out_r.pop_value <= pop_ok_r ? rdata_r : '0;
      out_r.status    <= status_r;
      out_r.occupancy <= OCC_W'(count_r);
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/dq_checker.sv -----
module dq_checker #(
  parameter int DEPTH = 16
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second command taken before result was produced");

  a_refused_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.pop_value == '0))
    else $error("refused command carries a pop value");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |-> (out_data.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.occupancy == FULL_OCC))
    else $error("full status with wrong occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind double_ended_queue_top dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
